// ----- rtl/hrsq_pkg.sv -----
// ----------------------------------------------------------------------------
// hrsq_pkg
// Shared types and constants of the retransmission search queue: entry
// layout, action codes, field widths and configuration register map.
// ----------------------------------------------------------------------------
package hrsq_pkg;

  localparam int unsigned USER_W   = 10;
  localparam int unsigned SLOT_W   = 16;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned COUNT_W  = 5;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_APPEND = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_TAKE   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_PEEK   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_DUE    = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd4;

  // configuration port
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;
  localparam logic        REG_RETX_MIN_AGE  = 1'b0;
  localparam logic [SLOT_W-1:0] MIN_AGE_RST = 16'd5;

  typedef struct packed {
    logic [USER_W-1:0]   user;
    logic [SLOT_W-1:0]   birth;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

endpackage

// ----- rtl/harq_retx_search_queue.sv -----
// ----------------------------------------------------------------------------
// harq_retx_search_queue
// Ordered queue of pending retransmission entries with append, take, peek,
// due check and clear, searched one entry per cycle by a shared compare unit.
//
//   channel  | ports                                  | handshake
//   ---------+----------------------------------------+-----------------
//   input    | in_action/user_id/birth/handle/now     | in_valid/in_ready
//   result   | out_hit/found_handle/dropped/not_empty/| out_valid/out_ready
//            | entry_count                            |
//   config   | psel/penable/pwrite/paddr/pwdata/prdata| pready (always 1)
//
// append, clear and unused codes go from accept through ST_POST to the output register.
// searches read one entry a cycle from the first until a hit or the fill count; a take
// hit then passes through ST_SHIFT, moving each later entry down one slot to close the gap.
// one item in work at a time, in_ready high only while idle.
// a result held by out_ready low stalls the sequencer before its return to idle.
// synchronous active-low reset empties the queue and sets the minimum age to 5.
// ----------------------------------------------------------------------------
module harq_retx_search_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [hrsq_pkg::ACTION_W-1:0]       in_action,
  input  logic [hrsq_pkg::USER_W-1:0]         in_user_id,
  input  logic [hrsq_pkg::SLOT_W-1:0]         in_birth_slot,
  input  logic [hrsq_pkg::HANDLE_W-1:0]       in_msg_handle,
  input  logic [hrsq_pkg::SLOT_W-1:0]         in_now_slot,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_hit,
  output logic [hrsq_pkg::HANDLE_W-1:0]       out_found_handle,
  output logic                                out_dropped,
  output logic                                out_not_empty,
  output logic [hrsq_pkg::COUNT_W-1:0]        out_entry_count,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [hrsq_pkg::CFG_AW-1:0]         paddr,
  input  logic [hrsq_pkg::CFG_DW-1:0]         pwdata,
  output logic [hrsq_pkg::CFG_DW-1:0]         prdata,
  output logic                                pready
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_SHIFT = 4'b0100,
    ST_POST  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [hrsq_pkg::ACTION_W-1:0] op_r, op_nxt;
  logic [hrsq_pkg::USER_W-1:0]   user_r, user_nxt;
  logic [hrsq_pkg::SLOT_W-1:0]   now_r, now_nxt;
  logic [CW-1:0]                 count_r, count_nxt;
  logic [CW-1:0]                 scan_idx_r, scan_idx_nxt;
  logic                          pend_r, pend_nxt;
  logic [AW-1:0]                 pend_idx_r, pend_idx_nxt;
  logic                          res_hit_r, res_hit_nxt;
  logic [hrsq_pkg::HANDLE_W-1:0] res_handle_r, res_handle_nxt;
  logic                          res_drop_r, res_drop_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic                          out_hit_r, out_hit_nxt;
  logic [hrsq_pkg::HANDLE_W-1:0] out_handle_r, out_handle_nxt;
  logic                          out_drop_r, out_drop_nxt;
  logic                          out_ne_r, out_ne_nxt;
  logic [hrsq_pkg::COUNT_W-1:0]  out_count_r, out_count_nxt;

  logic [hrsq_pkg::SLOT_W-1:0]   min_age;
  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  hrsq_pkg::entry_t              mem_wdata;
  hrsq_pkg::entry_t              mem_q;
  logic                          unit_match;
  logic                          match;
  logic                          out_free;

  hrsq_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .min_age (min_age)
  );

  hrsq_entry_mem #(
    .DEPTH (QUEUE_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (scan_idx_r[AW-1:0]),
    .rdata (mem_q)
  );

  hrsq_match_unit u_match (
    .entry     (mem_q),
    .user      (user_r),
    .now_slot  (now_r),
    .min_age   (min_age),
    .check_age (op_r == hrsq_pkg::ACT_DUE),
    .match     (unit_match)
  );

  assign in_ready = state_r == ST_IDLE;
  assign match    = pend_r && unit_match;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    user_nxt       = user_r;
    now_nxt        = now_r;
    count_nxt      = count_r;
    scan_idx_nxt   = scan_idx_r;
    pend_nxt       = pend_r;
    pend_idx_nxt   = pend_idx_r;
    res_hit_nxt    = res_hit_r;
    res_handle_nxt = res_handle_r;
    res_drop_nxt   = res_drop_r;
    mem_we         = 1'b0;
    mem_waddr      = count_r[AW-1:0];
    mem_wdata      = '{user: in_user_id, birth: in_birth_slot, handle: in_msg_handle};

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt         = in_action;
          user_nxt       = in_user_id;
          now_nxt        = in_now_slot;
          scan_idx_nxt   = '0;
          pend_nxt       = 1'b0;
          res_hit_nxt    = 1'b0;
          res_handle_nxt = '0;
          res_drop_nxt   = 1'b0;
          state_nxt      = ST_POST;
          case (in_action)
            hrsq_pkg::ACT_APPEND: begin
              if (count_r >= DEPTH_C) begin
                res_drop_nxt = 1'b1;
              end else begin
                mem_we    = 1'b1;
                count_nxt = count_r + ONE_C;
              end
            end
            hrsq_pkg::ACT_TAKE,
            hrsq_pkg::ACT_PEEK,
            hrsq_pkg::ACT_DUE: begin
              state_nxt = ST_SCAN;
            end
            hrsq_pkg::ACT_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
              state_nxt = ST_POST;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // check the entry read last cycle while the next read is issued
        if (match) begin
          res_hit_nxt    = 1'b1;
          res_handle_nxt = mem_q.handle;
          pend_nxt       = 1'b0;
          if (op_r == hrsq_pkg::ACT_TAKE) begin
            state_nxt = ST_SHIFT;
          end else begin
            state_nxt = ST_POST;
          end
        end else if (scan_idx_r == count_r) begin
          pend_nxt  = 1'b0;
          state_nxt = ST_POST;
        end else begin
          pend_nxt     = 1'b1;
          pend_idx_nxt = scan_idx_r[AW-1:0];
          scan_idx_nxt = scan_idx_r + ONE_C;
        end
      end
      ST_SHIFT: begin
        // entry read last cycle moves down one slot
        mem_we    = pend_r;
        mem_waddr = pend_idx_r - AW'(1);
        mem_wdata = mem_q;
        if (scan_idx_r == count_r) begin
          pend_nxt  = 1'b0;
          count_nxt = count_r - ONE_C;
          state_nxt = ST_POST;
        end else begin
          pend_nxt     = 1'b1;
          pend_idx_nxt = scan_idx_r[AW-1:0];
          scan_idx_nxt = scan_idx_r + ONE_C;
        end
      end
      ST_POST: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ready;
    out_hit_nxt    = out_hit_r;
    out_handle_nxt = out_handle_r;
    out_drop_nxt   = out_drop_r;
    out_ne_nxt     = out_ne_r;
    out_count_nxt  = out_count_r;
    if (state_r == ST_POST && out_free) begin
      out_valid_nxt  = 1'b1;
      out_hit_nxt    = res_hit_r;
      out_handle_nxt = res_handle_r;
      out_drop_nxt   = res_drop_r;
      out_ne_nxt     = count_r != '0;
      out_count_nxt  = hrsq_pkg::COUNT_W'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    user_r       <= user_nxt;
    now_r        <= now_nxt;
    scan_idx_r   <= scan_idx_nxt;
    pend_idx_r   <= pend_idx_nxt;
    res_hit_r    <= res_hit_nxt;
    res_handle_r <= res_handle_nxt;
    res_drop_r   <= res_drop_nxt;
    out_hit_r    <= out_hit_nxt;
    out_handle_r <= out_handle_nxt;
    out_drop_r   <= out_drop_nxt;
    out_ne_r     <= out_ne_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_found_handle = out_handle_r;
  assign out_dropped      = out_drop_r;
  assign out_not_empty    = out_ne_r;
  assign out_entry_count  = out_count_r;

endmodule

// ----- rtl/hrsq_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// hrsq_cfg_regs
// Register file behind the configuration port; holds the minimum age in
// slots before an entry is due for retransmission.
// ----------------------------------------------------------------------------
module hrsq_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hrsq_pkg::CFG_AW-1:0]    paddr,
  input  logic [hrsq_pkg::CFG_DW-1:0]    pwdata,
  output logic [hrsq_pkg::CFG_DW-1:0]    prdata,
  output logic                           pready,
  output logic [hrsq_pkg::SLOT_W-1:0]    min_age
);

  logic [hrsq_pkg::SLOT_W-1:0] min_age_r;
  logic [hrsq_pkg::SLOT_W-1:0] min_age_nxt;
  logic                        reg_sel;

  // register index is the word address
  assign reg_sel = paddr[2] == hrsq_pkg::REG_RETX_MIN_AGE;
  assign pready  = 1'b1;

  always_comb begin
    min_age_nxt = min_age_r;
    if (psel && penable && pwrite && reg_sel) begin
      min_age_nxt = pwdata[hrsq_pkg::SLOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_age_r <= hrsq_pkg::MIN_AGE_RST;
    end else begin
      min_age_r <= min_age_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata = {{(hrsq_pkg::CFG_DW-hrsq_pkg::SLOT_W){1'b0}}, min_age_r};
    end
  end

  assign min_age = min_age_r;

endmodule

// ----- rtl/hrsq_entry_mem.sv -----
// ----------------------------------------------------------------------------
// hrsq_entry_mem
// Entry storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hrsq_entry_mem #(
  parameter  int unsigned DEPTH = 16,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  hrsq_pkg::entry_t     wdata,
  input  logic [AW-1:0]        raddr,
  output hrsq_pkg::entry_t     rdata
);

  hrsq_pkg::entry_t mem_r [DEPTH];
  hrsq_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/hrsq_match_unit.sv -----
// ----------------------------------------------------------------------------
// hrsq_match_unit
// Shared compare unit: user match and, for the due check, slot age against
// the configured minimum (age wraps modulo 2^16).
// ----------------------------------------------------------------------------
module hrsq_match_unit (
  input  hrsq_pkg::entry_t               entry,
  input  logic [hrsq_pkg::USER_W-1:0]    user,
  input  logic [hrsq_pkg::SLOT_W-1:0]    now_slot,
  input  logic [hrsq_pkg::SLOT_W-1:0]    min_age,
  input  logic                           check_age,
  output logic                           match
);

  logic [hrsq_pkg::SLOT_W-1:0] age;

  assign age   = now_slot - entry.birth;
  assign match = (entry.user == user) && (!check_age || (age >= min_age));

endmodule

// ----- rtl/hrsq_checker.sv -----
// ----------------------------------------------------------------------------
// hrsq_checker
// Port-level checks on the result channel of the search queue.
// ----------------------------------------------------------------------------
module hrsq_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           out_hit,
  input logic [hrsq_pkg::HANDLE_W-1:0]  out_found_handle,
  input logic                           out_dropped,
  input logic                           out_not_empty,
  input logic [hrsq_pkg::COUNT_W-1:0]   out_entry_count
);

  // no hit means a zero handle
  a_miss_zero_handle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_found_handle == '0)
    else $error("handle nonzero without hit");

  // a dropped append never reports a hit
  a_drop_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dropped |-> !out_hit)
    else $error("hit and dropped together");

  // a nonzero count means the queue is not empty
  a_count_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_entry_count != '0 |-> out_not_empty)
    else $error("count nonzero but queue flagged empty");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit) &&
      $stable(out_found_handle) && $stable(out_dropped) &&
      $stable(out_not_empty) && $stable(out_entry_count))
    else $error("stalled item changed");

endmodule

bind harq_retx_search_queue hrsq_checker u_hrsq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_hit          (out_hit),
  .out_found_handle (out_found_handle),
  .out_dropped      (out_dropped),
  .out_not_empty    (out_not_empty),
  .out_entry_count  (out_entry_count)
);

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for harq_retx_search_queue. A tracker class keeps its
// own copy of the retransmission queue, predicts the status item of every
// accepted request and compares it with the block's output in order.
// Directed requests cover empty, full and wrap-around cases; random phases
// run with several minimum ages, random idling on both channels and a long
// result back-pressure stretch.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned HOLD_LEN   = 300;
  localparam int unsigned PHASE_REQS = 250;
  localparam logic [hrsq_pkg::ACTION_W-1:0] ACT_UNUSED_LO = 3'd5;
  localparam logic [hrsq_pkg::ACTION_W-1:0] ACT_UNUSED_HI = 3'd7;
  localparam logic [hrsq_pkg::CFG_AW-1:0]   MIN_AGE_ADDR  =
    {hrsq_pkg::REG_RETX_MIN_AGE, 2'b00};

  typedef struct packed {
    logic [hrsq_pkg::ACTION_W-1:0] action;
    logic [hrsq_pkg::USER_W-1:0]   user;
    logic [hrsq_pkg::SLOT_W-1:0]   birth;
    logic [hrsq_pkg::HANDLE_W-1:0] handle;
    logic [hrsq_pkg::SLOT_W-1:0]   now;
  } req_t;

  typedef struct packed {
    logic                          hit;
    logic [hrsq_pkg::HANDLE_W-1:0] handle;
    logic                          dropped;
    logic                          not_empty;
    logic [hrsq_pkg::COUNT_W-1:0]  count;
  } rsp_t;

  class retx_queue_tracker;
    logic [hrsq_pkg::USER_W-1:0]   ent_user   [DEPTH];
    logic [hrsq_pkg::SLOT_W-1:0]   ent_birth  [DEPTH];
    logic [hrsq_pkg::HANDLE_W-1:0] ent_handle [DEPTH];
    int unsigned                   fill;
    logic [hrsq_pkg::SLOT_W-1:0]   min_age;
    rsp_t                          awaited[$];
    int unsigned                   errors;
    int unsigned                   n_requests;
    int unsigned                   n_responses;
    int unsigned                   n_drops;
    int unsigned                   n_hits;
    int unsigned                   n_full;

    function new();
      fill        = 0;
      min_age     = hrsq_pkg::MIN_AGE_RST;
      errors      = 0;
      n_requests  = 0;
      n_responses = 0;
      n_drops     = 0;
      n_hits      = 0;
      n_full      = 0;
    endfunction

    function int first_of(logic [hrsq_pkg::USER_W-1:0] u);
      for (int i = 0; i < int'(fill); i++) begin
        if (ent_user[i] == u) return i;
      end
      return -1;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function void accept_request(req_t r);
      rsp_t                        e;
      int                          pos;
      logic [hrsq_pkg::SLOT_W-1:0] age;
      e = '0;
      n_requests++;
      case (r.action)
        hrsq_pkg::ACT_APPEND: begin
          if (fill >= DEPTH) begin
            e.dropped = 1'b1;
            n_drops++;
          end else begin
            ent_user[fill]   = r.user;
            ent_birth[fill]  = r.birth;
            ent_handle[fill] = r.handle;
            fill++;
            if (fill == DEPTH) n_full++;
          end
        end
        hrsq_pkg::ACT_TAKE, hrsq_pkg::ACT_PEEK: begin
          pos = first_of(r.user);
          if (pos >= 0) begin
            e.hit    = 1'b1;
            e.handle = ent_handle[pos];
            if (r.action == hrsq_pkg::ACT_TAKE) begin
              // close the gap, order of the rest kept
              for (int i = pos; i + 1 < int'(fill); i++) begin
                ent_user[i]   = ent_user[i+1];
                ent_birth[i]  = ent_birth[i+1];
                ent_handle[i] = ent_handle[i+1];
              end
              fill--;
            end
          end
        end
        hrsq_pkg::ACT_DUE: begin
          for (int i = 0; i < int'(fill); i++) begin
            age = r.now - ent_birth[i];
            if (ent_user[i] == r.user && age >= min_age) begin
              e.hit    = 1'b1;
              e.handle = ent_handle[i];
              break;
            end
          end
        end
        hrsq_pkg::ACT_CLEAR: fill = 0;
        default: ;
      endcase
      if (e.hit) n_hits++;
      e.not_empty = (fill != 0);
      e.count     = hrsq_pkg::COUNT_W'(fill);
      awaited.insert(awaited.size(), e);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
        errors++;
        if (errors <= 40)
          $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, seen);
      end
    endfunction

    function void check_response(rsp_t got);
      rsp_t e;
      n_responses++;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: result item with none expected, expected none, actual %0h",
                   $time, got);
        return;
      end
      e = awaited[0];
      awaited.delete(0);
      compare("hit", 32'(e.hit), 32'(got.hit));
      compare("found_handle", 32'(e.handle), 32'(got.handle));
      compare("dropped", 32'(e.dropped), 32'(got.dropped));
      compare("not_empty", 32'(e.not_empty), 32'(got.not_empty));
      compare("entry_count", 32'(e.count), 32'(got.count));
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [hrsq_pkg::ACTION_W-1:0] in_action = '0;
  logic [hrsq_pkg::USER_W-1:0]   in_user_id = '0;
  logic [hrsq_pkg::SLOT_W-1:0]   in_birth_slot = '0;
  logic [hrsq_pkg::HANDLE_W-1:0] in_msg_handle = '0;
  logic [hrsq_pkg::SLOT_W-1:0]   in_now_slot = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          out_hit;
  logic [hrsq_pkg::HANDLE_W-1:0] out_found_handle;
  logic                          out_dropped;
  logic                          out_not_empty;
  logic [hrsq_pkg::COUNT_W-1:0]  out_entry_count;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [hrsq_pkg::CFG_AW-1:0]   paddr = '0;
  logic [hrsq_pkg::CFG_DW-1:0]   pwdata = '0;
  logic [hrsq_pkg::CFG_DW-1:0]   prdata;
  logic                          pready;

  retx_queue_tracker             tracker = new();
  bit                            quiet = 1'b0;
  int unsigned                   hold_requests = 0;
  int unsigned                   holds_served = 0;
  int unsigned                   hold_left = 0;
  logic [hrsq_pkg::USER_W-1:0]   user_pool [4];

  harq_retx_search_queue #(.QUEUE_DEPTH(DEPTH)) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_user_id       (in_user_id),
    .in_birth_slot    (in_birth_slot),
    .in_msg_handle    (in_msg_handle),
    .in_now_slot      (in_now_slot),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_hit          (out_hit),
    .out_found_handle (out_found_handle),
    .out_dropped      (out_dropped),
    .out_not_empty    (out_not_empty),
    .out_entry_count  (out_entry_count),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #6 clk = ~clk;

  // result side: check, then pick next ready (one assignment per edge)
  always @(posedge clk) begin : result_side
    rsp_t got;
    if (rst_n && out_valid && out_ready) begin
      got.hit       = out_hit;
      got.handle    = out_found_handle;
      got.dropped   = out_dropped;
      got.not_empty = out_not_empty;
      got.count     = out_entry_count;
      tracker.check_response(got);
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (holds_served < hold_requests) begin
      holds_served++;
      hold_left = HOLD_LEN;
      out_ready <= 1'b0;
    end else if (quiet) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= 15);
    end
  end

  initial begin
    #10_000_000;
    $display("FAIL harq_retx_search_queue");
    $finish;
  end

  // leaves valid high at the accepting edge so back-to-back items need no toggle
  task automatic send_request(req_t r);
    int unsigned gap;
    gap = 0;
    if (!quiet) begin
      while ($urandom_range(0, 99) < 15) gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= r.action;
    in_user_id    <= r.user;
    in_birth_slot <= r.birth;
    in_msg_handle <= r.handle;
    in_now_slot   <= r.now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.accept_request(r);
  endtask

  task automatic send(logic [hrsq_pkg::ACTION_W-1:0] act,
                      logic [hrsq_pkg::USER_W-1:0] user,
                      logic [hrsq_pkg::SLOT_W-1:0] birth,
                      logic [hrsq_pkg::HANDLE_W-1:0] handle,
                      logic [hrsq_pkg::SLOT_W-1:0] now);
    req_t r;
    r.action = act;
    r.user   = user;
    r.birth  = birth;
    r.handle = handle;
    r.now    = now;
    send_request(r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_min_age(logic [hrsq_pkg::SLOT_W-1:0] v);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= MIN_AGE_ADDR;
    pwdata  <= hrsq_pkg::CFG_DW'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.min_age = v;
    @(posedge clk);
    // read back
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    tracker.compare("retx_min_age readback", hrsq_pkg::CFG_DW'(v), prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [hrsq_pkg::USER_W-1:0] pick_user();
    if ($urandom_range(0, 99) < 85) return user_pool[$urandom_range(0, 3)];
    return hrsq_pkg::USER_W'($urandom_range(0, 1023));
  endfunction

  // searches mostly aimed at queued users, due checks near the age threshold
  function automatic req_t next_request();
    req_t        r;
    int unsigned roll;
    int unsigned append_pct;
    int unsigned j;
    r.user   = pick_user();
    r.birth  = hrsq_pkg::SLOT_W'($urandom());
    r.handle = hrsq_pkg::HANDLE_W'($urandom());
    r.now    = hrsq_pkg::SLOT_W'($urandom());
    append_pct = (tracker.fill < 4) ? 55 : (tracker.fill >= 14) ? 22 : 38;
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      r.action = hrsq_pkg::ACTION_W'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
    end else if (roll < 5) begin
      r.action = hrsq_pkg::ACT_CLEAR;
    end else if (roll < 5 + append_pct) begin
      r.action = hrsq_pkg::ACT_APPEND;
    end else begin
      case ($urandom_range(0, 2))
        0:       r.action = hrsq_pkg::ACT_TAKE;
        1:       r.action = hrsq_pkg::ACT_PEEK;
        default: r.action = hrsq_pkg::ACT_DUE;
      endcase
      if (tracker.fill > 0 && $urandom_range(0, 9) < 8) begin
        j = $urandom_range(0, tracker.fill - 1);
        r.user = tracker.ent_user[j];
        if (r.action == hrsq_pkg::ACT_DUE)
          r.now = tracker.ent_birth[j] + tracker.min_age
                  + hrsq_pkg::SLOT_W'($urandom_range(0, 4)) - hrsq_pkg::SLOT_W'(2);
      end
    end
    return r;
  endfunction

  task automatic random_phase(int unsigned n, bit hold_once);
    req_t        r;
    int unsigned counted;
    counted = 0;
    user_pool[0] = '0;
    user_pool[1] = '1;
    user_pool[2] = hrsq_pkg::USER_W'($urandom_range(0, 1023));
    user_pool[3] = hrsq_pkg::USER_W'($urandom_range(0, 1023));
    while (counted < n) begin
      if (hold_once && counted == n / 3) hold_requests++;
      r = next_request();
      send_request(r);
      if (r.action < ACT_UNUSED_LO) counted++;
    end
  endtask

  initial begin : stimulus
    logic [hrsq_pkg::SLOT_W-1:0] ages [5];
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue, unused codes
    send(hrsq_pkg::ACT_TAKE, '0, '0, '0, '0);
    send(hrsq_pkg::ACT_PEEK, '1, '1, '1, '1);
    send(hrsq_pkg::ACT_DUE, '1, '0, '0, '1);
    send(ACT_UNUSED_LO, '1, '1, '1, '1);
    send(ACT_UNUSED_HI, '0, '0, '0, '0);
    // age wraps through zero at the reset minimum age
    send(hrsq_pkg::ACT_APPEND, '1, '1, '1, '0);
    send(hrsq_pkg::ACT_APPEND, '0, '0, '0, '1);
    send(hrsq_pkg::ACT_DUE, '1, '0, '0, 16'd4);
    send(hrsq_pkg::ACT_DUE, '1, '0, '0, 16'd3);
    send(hrsq_pkg::ACT_DUE, '0, '1, '1, 16'd5);
    send(hrsq_pkg::ACT_PEEK, '0, '0, '0, '0);
    send(hrsq_pkg::ACT_TAKE, '1, '0, '0, '0);
    // fill to the top, then one append too many
    for (int i = 0; i < 15; i++)
      send(hrsq_pkg::ACT_APPEND,
           (i % 3 == 0) ? hrsq_pkg::USER_W'(0) : hrsq_pkg::USER_W'($urandom_range(0, 1023)),
           hrsq_pkg::SLOT_W'($urandom()), hrsq_pkg::HANDLE_W'($urandom()), '0);
    send(hrsq_pkg::ACT_APPEND, 10'h155, 16'haaaa, 16'h5555, '0);
    send(hrsq_pkg::ACT_TAKE, '0, '0, '0, '0);
    send(hrsq_pkg::ACT_CLEAR, '0, '0, '0, '0);
    drain();

    ages[0] = '0;
    ages[1] = '1;
    ages[2] = hrsq_pkg::SLOT_W'($urandom_range(1, 40));
    ages[3] = hrsq_pkg::SLOT_W'($urandom());
    ages[4] = 16'd7;
    for (int p = 0; p < 5; p++) begin
      write_min_age(ages[p]);
      quiet = (p == 1);
      random_phase(PHASE_REQS, p == 2);
      drain();
    end
    quiet = 1'b0;
    repeat (20) @(posedge clk);

    $display("covered %0d requests, %0d results, %0d hits, %0d full-queue drops,",
             tracker.n_requests, tracker.n_responses, tracker.n_hits, tracker.n_drops);
    $display("queue filled to the top %0d times, five minimum ages incl. 0 and 65535",
             tracker.n_full);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("PASS harq_retx_search_queue");
    end else begin
      $display("FAIL harq_retx_search_queue");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/hrsq_pkg.sv
rtl/hrsq_cfg_regs.sv
rtl/hrsq_entry_mem.sv
rtl/hrsq_match_unit.sv
rtl/harq_retx_search_queue.sv
rtl/hrsq_checker.sv
verif/tb.sv
